@@ hw/rtl/mck_pkg.sv @@
// Shared types, constants and the letter table for the Morse keyer.
// Used by mck_front, mck_queue, mck_back and morse_code_keyer.
package mck_pkg;

  localparam int unsigned TimeWidth    = 16;
  localparam int unsigned CodeWidth    = 8;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [TimeWidth-1:0] DotTimeReset     = 16'd200;
  localparam logic [TimeWidth-1:0] DashTimeReset    = 16'd600;
  localparam logic [TimeWidth-1:0] ElemGapTimeReset = 16'd200;
  localparam logic [TimeWidth-1:0] LetterGapReset   = 16'd600;
  localparam logic [TimeWidth-1:0] WordGapReset     = 16'd1400;

  localparam logic [CodeWidth-1:0] CharLowerA = 8'h61;
  localparam logic [CodeWidth-1:0] CharLowerZ = 8'h7a;
  localparam logic [CodeWidth-1:0] CharUpperA = 8'h41;
  localparam logic [CodeWidth-1:0] CharUpperZ = 8'h5a;
  localparam logic [CodeWidth-1:0] CharSpace  = 8'h20;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DOT_TIME      = 3'd0,
    REG_DASH_TIME     = 3'd1,
    REG_ELEM_GAP_TIME = 3'd2,
    REG_LETTER_GAP    = 3'd3,
    REG_WORD_GAP      = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_LETTER = 2'd0,
    KIND_SPACE  = 2'd1,
    KIND_BAD    = 2'd2
  } char_kind_t;

  typedef struct packed {
    logic [1:0] last_idx;
    logic [3:0] dashes;
  } morse_shape_t;

  typedef struct packed {
    char_kind_t   kind;
    morse_shape_t shape;
  } char_desc_t;

  typedef struct packed {
    logic [TimeWidth-1:0] dot_time;
    logic [TimeWidth-1:0] dash_time;
    logic [TimeWidth-1:0] element_gap_time;
    logic [TimeWidth-1:0] letter_gap_time;
    logic [TimeWidth-1:0] word_gap_time;
  } timing_t;

  // bit i of dashes is set when element i is a dash
  function automatic morse_shape_t morse_lookup(input logic [4:0] letter);
    morse_shape_t s;
    case (letter)
      5'd0:    s = '{2'd1, 4'b0010};
      5'd1:    s = '{2'd3, 4'b0001};
      5'd2:    s = '{2'd3, 4'b0101};
      5'd3:    s = '{2'd2, 4'b0001};
      5'd4:    s = '{2'd0, 4'b0000};
      5'd5:    s = '{2'd3, 4'b0100};
      5'd6:    s = '{2'd2, 4'b0011};
      5'd7:    s = '{2'd3, 4'b0000};
      5'd8:    s = '{2'd1, 4'b0000};
      5'd9:    s = '{2'd3, 4'b1110};
      5'd10:   s = '{2'd2, 4'b0101};
      5'd11:   s = '{2'd3, 4'b0010};
      5'd12:   s = '{2'd1, 4'b0011};
      5'd13:   s = '{2'd1, 4'b0001};
      5'd14:   s = '{2'd2, 4'b0111};
      5'd15:   s = '{2'd3, 4'b0110};
      5'd16:   s = '{2'd3, 4'b1011};
      5'd17:   s = '{2'd2, 4'b0010};
      5'd18:   s = '{2'd2, 4'b0000};
      5'd19:   s = '{2'd0, 4'b0001};
      5'd20:   s = '{2'd2, 4'b0100};
      5'd21:   s = '{2'd3, 4'b1000};
      5'd22:   s = '{2'd2, 4'b0110};
      5'd23:   s = '{2'd3, 4'b1001};
      5'd24:   s = '{2'd3, 4'b1101};
      5'd25:   s = '{2'd3, 4'b0011};
      default: s = '{2'd0, 4'b0000};
    endcase
    return s;
  endfunction

endpackage

@@ hw/rtl/mck_front.sv @@
// Front end of the Morse keyer: classifies a character code into a descriptor.
// Depends on mck_pkg for the character constants and the letter table.
module mck_front import mck_pkg::*; (
  input  logic [CodeWidth-1:0] char_code,
  output char_desc_t           desc
);

  logic [CodeWidth-1:0] lower_off;
  logic [CodeWidth-1:0] upper_off;

  assign lower_off = char_code - CharLowerA;
  assign upper_off = char_code - CharUpperA;

  always_comb begin
    desc.kind  = KIND_BAD;
    desc.shape = '{2'd0, 4'b0000};
    if (char_code inside {[CharLowerA:CharLowerZ]}) begin
      desc.kind  = KIND_LETTER;
      desc.shape = morse_lookup(lower_off[4:0]);
    end else if (char_code inside {[CharUpperA:CharUpperZ]}) begin
      desc.kind  = KIND_LETTER;
      desc.shape = morse_lookup(upper_off[4:0]);
    end else if (char_code == CharSpace) begin
      desc.kind = KIND_SPACE;
    end
  end

endmodule

@@ hw/rtl/mck_queue.sv @@
// Small descriptor queue between the front end and the segment sequencer.
// Depends on mck_pkg for the descriptor type.
module mck_queue import mck_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  char_desc_t push_data,
  output logic       full,
  input  logic       pop,
  output char_desc_t pop_data,
  output logic       empty
);

  localparam int unsigned PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QUEUE_DEPTH - 1);
  localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(QUEUE_DEPTH);

  char_desc_t           mem [QUEUE_DEPTH];
  logic [PtrWidth-1:0]  wr_ptr;
  logic [PtrWidth-1:0]  rd_ptr;
  logic [CntWidth-1:0]  count;
  logic                 do_push;
  logic                 do_pop;

  assign full     = (count == DepthCnt);
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/mck_back.sv @@
// Segment sequencer of the Morse keyer: expands descriptors into key segments
// and holds the oldest result in an output register. Depends on mck_pkg.
module mck_back import mck_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  timing_t              timing,
  input  char_desc_t           desc,
  input  logic                 desc_empty,
  output logic                 desc_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic                 key_level,
  output logic [TimeWidth-1:0] segment_time,
  output logic                 bad_char,
  output logic                 last_segment
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ON,
    S_GAP,
    S_TAIL
  } seq_state_t;

  seq_state_t   state;
  morse_shape_t shape;
  logic [1:0]   idx;
  logic         out_valid;
  logic         out_free;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign desc_pop = (state == S_IDLE) && out_free && !desc_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (out_free) begin
      out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!desc_empty) begin
            out_valid <= 1'b1;
            shape     <= desc.shape;
            idx       <= '0;
            case (desc.kind)
              KIND_LETTER: begin
                key_level    <= 1'b1;
                segment_time <= desc.shape.dashes[0] ? timing.dash_time : timing.dot_time;
                bad_char     <= 1'b0;
                last_segment <= 1'b0;
                state        <= S_GAP;
              end
              KIND_SPACE: begin
                key_level    <= 1'b0;
                segment_time <= timing.word_gap_time;
                bad_char     <= 1'b0;
                last_segment <= 1'b1;
              end
              default: begin
                key_level    <= 1'b0;
                segment_time <= '0;
                bad_char     <= 1'b1;
                last_segment <= 1'b1;
              end
            endcase
          end
        end
        S_ON: begin
          out_valid    <= 1'b1;
          key_level    <= 1'b1;
          segment_time <= shape.dashes[idx] ? timing.dash_time : timing.dot_time;
          bad_char     <= 1'b0;
          last_segment <= 1'b0;
          state        <= S_GAP;
        end
        S_GAP: begin
          out_valid    <= 1'b1;
          key_level    <= 1'b0;
          segment_time <= timing.element_gap_time;
          bad_char     <= 1'b0;
          last_segment <= 1'b0;
          if (idx == shape.last_idx) begin
            state <= S_TAIL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_ON;
          end
        end
        S_TAIL: begin
          out_valid    <= 1'b1;
          key_level    <= 1'b0;
          segment_time <= timing.letter_gap_time;
          bad_char     <= 1'b0;
          last_segment <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    desc_pop |-> state == S_IDLE)
    else $error("descriptor taken while a character is still expanding");

  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_char |-> segment_time == '0 && last_segment && !key_level)
    else $error("error result carries a duration or key level");

  a_on_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_level |-> !last_segment && !bad_char)
    else $error("key-on segment marked as final");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> idx <= shape.last_idx)
    else $error("element index beyond letter length");

  a_expand_after_letter: assert property (@(posedge clk) disable iff (rst)
    desc_pop && desc.kind == KIND_LETTER |=> state == S_GAP && out_valid && key_level)
    else $error("letter did not start with a key-on segment");
`endif

endmodule

@@ hw/rtl/morse_code_keyer.sv @@
// Morse keyer top level: configuration registers, front end, descriptor queue
// and segment sequencer. Depends on mck_pkg, mck_front, mck_queue, mck_back.
//
// Push one ASCII code per transaction; each comes back as a run of key
// segments (level, duration) on the result side, popped one per transaction.
// A letter of n elements gives 2n+1 segments, one per clock while pop is
// held; a space or an unsupported code gives one. The sequencer's single
// output register sets that pace, and a QUEUE_DEPTH-entry descriptor queue
// lets the input side keep taking characters while segments wait. The user
// must write timing registers through cfg_wr_en/cfg_index/cfg_data only while
// no transaction is pending; the block itself does not enforce this.
module morse_code_keyer import mck_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CfgIdxWidth-1:0] cfg_index,
  input  logic [TimeWidth-1:0]   cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [CodeWidth-1:0]   char_code,
  output logic                   empty,
  input  logic                   pop,
  output logic                   key_level,
  output logic [TimeWidth-1:0]   segment_time,
  output logic                   bad_char,
  output logic                   last_segment
);

  timing_t    timing;
  char_desc_t front_desc;
  char_desc_t queue_desc;
  logic       queue_empty;
  logic       queue_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      timing.dot_time         <= DotTimeReset;
      timing.dash_time        <= DashTimeReset;
      timing.element_gap_time <= ElemGapTimeReset;
      timing.letter_gap_time  <= LetterGapReset;
      timing.word_gap_time    <= WordGapReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DOT_TIME:      timing.dot_time         <= cfg_data;
        REG_DASH_TIME:     timing.dash_time        <= cfg_data;
        REG_ELEM_GAP_TIME: timing.element_gap_time <= cfg_data;
        REG_LETTER_GAP:    timing.letter_gap_time  <= cfg_data;
        REG_WORD_GAP:      timing.word_gap_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  mck_front u_front (
    .char_code (char_code),
    .desc      (front_desc)
  );

  mck_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_desc),
    .full      (full),
    .pop       (queue_pop),
    .pop_data  (queue_desc),
    .empty     (queue_empty)
  );

  mck_back u_back (
    .clk          (clk),
    .rst          (rst),
    .timing       (timing),
    .desc         (queue_desc),
    .desc_empty   (queue_empty),
    .desc_pop     (queue_pop),
    .empty        (empty),
    .pop          (pop),
    .key_level    (key_level),
    .segment_time (segment_time),
    .bad_char     (bad_char),
    .last_segment (last_segment)
  );

endmodule
